### sv/double_array_trie_prefix_match_macros.svh
// Assertion macros for the checker file dtpm_checker.sv.
`ifndef DOUBLE_ARRAY_TRIE_PREFIX_MATCH_MACROS_SVH
`define DOUBLE_ARRAY_TRIE_PREFIX_MATCH_MACROS_SVH

// Checked only outside reset.
`define DTPM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define DTPM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### sv/dtpm_pkg.sv
package dtpm_pkg;

    localparam int NODE_W    = 30;
    localparam int WORD_W    = 32;
    localparam int LEN_OUT_W = 12;
    localparam int OFS_W     = 31;
    localparam int TW_W      = 17;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_MATCH = 1'b1;

    localparam logic [0:0] REG_TRIE_WORDS   = 1'b0;
    localparam logic [0:0] REG_STRING_BYTES = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_VALUE = 3'b100
    } walk_state_t;

    typedef struct packed {
        logic        command;
        logic [15:0] node_index;
        logic [31:0] node_word;
        logic [7:0]  text_byte;
        logic        first_byte;
        logic        last_byte;
    } item_t;

    typedef struct packed {
        logic                 found;
        logic [LEN_OUT_W-1:0] length;
        logic [OFS_W-1:0]     offset;
    } result_t;

    // Base field of a node word: bits 31..10, optionally shifted up by a byte.
    function automatic logic [NODE_W-1:0] word_base(input logic [WORD_W-1:0] w);
        logic [NODE_W-1:0] b;
        b = w[9] ? {w[31:10], 8'b0} : {8'b0, w[31:10]};
        return b;
    endfunction

endpackage

### sv/dtpm_ram.sv
module dtpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/dtpm_walker.sv
module dtpm_walker #(
    parameter int TRIE_DEPTH    = 65536,
    parameter int MAX_MATCH_LEN = 4095
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           item_valid,
    input  dtpm_pkg::item_t                item,
    output logic                           item_take,
    input  logic                           out_free,
    input  logic [dtpm_pkg::TW_W-1:0]      trie_words,
    input  logic [dtpm_pkg::OFS_W-1:0]     string_bytes,
    output logic                           res_valid,
    output dtpm_pkg::result_t              res
);

    localparam int AW = $clog2(TRIE_DEPTH);
    localparam int DW = $clog2(MAX_MATCH_LEN + 1);

    dtpm_pkg::walk_state_t state_reg, state_next;
    logic [dtpm_pkg::NODE_W-1:0] node_reg, node_next;
    logic                        alive_reg, alive_next;
    logic [DW-1:0]               depth_reg, depth_next;
    logic [DW-1:0]               best_len_reg, best_len_next;
    logic [dtpm_pkg::OFS_W-1:0]  best_ofs_reg, best_ofs_next;
    logic [7:0]                  byte_reg, byte_next;
    logic                        last_reg, last_next;
    logic                        rd_ok_reg, rd_ok_next;
    logic [dtpm_pkg::WORD_W-1:0] word0_reg;

    logic                        ram_en, ram_we;
    logic [AW-1:0]               ram_addr;
    logic [dtpm_pkg::WORD_W-1:0] ram_rdata;

    logic                        take_ok;
    logic [31:0]                 ld_idx;
    logic                        ld_ok;
    logic [dtpm_pkg::NODE_W-1:0] start_node, probe_node, hop_node;
    logic                        start_alive;
    logic [DW-1:0]               start_depth, start_len, depth_inc;
    logic [dtpm_pkg::OFS_W-1:0]  start_ofs;
    logic [dtpm_pkg::WORD_W-1:0] rd_word;
    logic                        hit;
    logic                        fin, fin_last;
    logic [DW-1:0]               fin_len;
    logic [dtpm_pkg::OFS_W-1:0]  fin_ofs;
    logic [DW+dtpm_pkg::LEN_OUT_W-1:0] len_ext;
    logic                        found;

    function automatic logic in_range(input logic [dtpm_pkg::NODE_W-1:0] n,
                                      input logic [dtpm_pkg::TW_W-1:0]   tw);
        logic lim_a, lim_b;
        lim_a = n < {{(dtpm_pkg::NODE_W - dtpm_pkg::TW_W){1'b0}}, tw};
        lim_b = n < dtpm_pkg::NODE_W'(TRIE_DEPTH);
        return lim_a && lim_b;
    endfunction

    dtpm_ram #(
        .WIDTH (dtpm_pkg::WORD_W),
        .DEPTH (TRIE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (item.node_word),
        .rdata (ram_rdata)
    );

    assign ld_idx = {16'b0, item.node_index};
    assign ld_ok  = ld_idx < 32'(TRIE_DEPTH);

    // A byte restarts the walk at the root when it opens a query.
    assign start_alive = item.first_byte ? (trie_words != '0) : alive_reg;
    assign start_node  = item.first_byte ? dtpm_pkg::word_base(word0_reg) : node_reg;
    assign start_depth = item.first_byte ? '0 : depth_reg;
    assign start_len   = item.first_byte ? '0 : best_len_reg;
    assign start_ofs   = item.first_byte ? '0 : best_ofs_reg;
    assign probe_node  = start_node ^ {{(dtpm_pkg::NODE_W - 8){1'b0}}, item.text_byte};

    // Out-of-range reads come back as the zero word.
    assign rd_word   = rd_ok_reg ? ram_rdata : '0;
    assign hit       = !rd_word[31] && (rd_word[7:0] == byte_reg);
    assign hop_node  = node_reg ^ dtpm_pkg::word_base(rd_word);
    assign depth_inc = (depth_reg < DW'(MAX_MATCH_LEN)) ? depth_reg + 1'b1 : depth_reg;

    // A result-bearing byte waits until the output register is sure to be free.
    assign take_ok = item_valid &&
                     (item.command == dtpm_pkg::CMD_LOAD || !item.last_byte || out_free);

    always_comb begin
        state_next    = state_reg;
        node_next     = node_reg;
        alive_next    = alive_reg;
        depth_next    = depth_reg;
        best_len_next = best_len_reg;
        best_ofs_next = best_ofs_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        rd_ok_next    = rd_ok_reg;
        ram_en        = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = node_reg[AW-1:0];
        item_take     = 1'b0;
        fin           = 1'b0;
        fin_last      = last_reg;
        fin_len       = best_len_reg;
        fin_ofs       = best_ofs_reg;
        case (state_reg)
            dtpm_pkg::ST_IDLE: begin
                if (take_ok) begin
                    item_take = 1'b1;
                    if (item.command == dtpm_pkg::CMD_LOAD) begin
                        ram_en   = ld_ok;
                        ram_we   = ld_ok;
                        ram_addr = ld_idx[AW-1:0];
                    end else begin
                        alive_next    = start_alive;
                        node_next     = start_node;
                        depth_next    = start_depth;
                        best_len_next = start_len;
                        best_ofs_next = start_ofs;
                        byte_next     = item.text_byte;
                        last_next     = item.last_byte;
                        if (start_alive) begin
                            node_next  = probe_node;
                            ram_en     = 1'b1;
                            ram_addr   = probe_node[AW-1:0];
                            rd_ok_next = in_range(probe_node, trie_words);
                            state_next = dtpm_pkg::ST_CHECK;
                        end else begin
                            fin      = 1'b1;
                            fin_last = item.last_byte;
                            fin_len  = start_len;
                            fin_ofs  = start_ofs;
                        end
                    end
                end
            end
            dtpm_pkg::ST_CHECK: begin
                if (!hit) begin
                    alive_next = 1'b0;
                    fin        = 1'b1;
                    state_next = dtpm_pkg::ST_IDLE;
                end else begin
                    node_next  = hop_node;
                    depth_next = depth_inc;
                    if (rd_word[8]) begin
                        // Leaf: fetch the value word at the node just entered.
                        best_len_next = depth_inc;
                        ram_en        = 1'b1;
                        ram_addr      = hop_node[AW-1:0];
                        rd_ok_next    = in_range(hop_node, trie_words);
                        state_next    = dtpm_pkg::ST_VALUE;
                    end else begin
                        fin        = 1'b1;
                        state_next = dtpm_pkg::ST_IDLE;
                    end
                end
            end
            dtpm_pkg::ST_VALUE: begin
                best_ofs_next = rd_word[dtpm_pkg::OFS_W-1:0];
                fin           = 1'b1;
                fin_ofs       = rd_word[dtpm_pkg::OFS_W-1:0];
                state_next    = dtpm_pkg::ST_IDLE;
            end
            default: begin
                state_next = dtpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dtpm_pkg::ST_IDLE;
            node_reg     <= '0;
            alive_reg    <= 1'b0;
            depth_reg    <= '0;
            best_len_reg <= '0;
            best_ofs_reg <= '0;
        end else begin
            state_reg    <= state_next;
            node_reg     <= node_next;
            alive_reg    <= alive_next;
            depth_reg    <= depth_next;
            best_len_reg <= best_len_next;
            best_ofs_reg <= best_ofs_next;
        end
    end

    // Root word is mirrored so a query start needs no extra read.
    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        rd_ok_reg <= rd_ok_next;
        if (item_take && item.command == dtpm_pkg::CMD_LOAD && item.node_index == 16'd0) begin
            word0_reg <= item.node_word;
        end
    end

    assign len_ext    = {{dtpm_pkg::LEN_OUT_W{1'b0}}, fin_len};
    assign found      = (fin_len != '0) && (fin_ofs < string_bytes);
    assign res_valid  = fin && fin_last;
    assign res.found  = found;
    assign res.length = found ? len_ext[dtpm_pkg::LEN_OUT_W-1:0] : '0;
    assign res.offset = found ? fin_ofs : '0;

endmodule

### sv/double_array_trie_prefix_match.sv
// A live match byte reads its trie slot, then checks it; a leaf also reads its value.
// Bytes share the single trie RAM port: each hop's read feeds the next byte's address.
// Results come from an output register, loaded in the cycle after a last byte finishes.
// A one-item input buffer lets the next transfer land while a byte is still walking.
// aresetn (synchronous) clears the walk and both registers; the trie RAM is not cleared.
module double_array_trie_prefix_match #(
    parameter int TRIE_DEPTH    = 65536,
    parameter int MAX_MATCH_LEN = 4095
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [15:0] s_node_index,
    input  logic [31:0] s_node_word,
    input  logic [7:0]  s_text_byte,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_match_found,
    output logic [11:0] m_match_length,
    output logic [30:0] m_value_offset
);

    logic [dtpm_pkg::TW_W-1:0]  trie_words_reg;
    logic [dtpm_pkg::OFS_W-1:0] string_bytes_reg;
    logic                       cfg_wr;

    dtpm_pkg::item_t   buf_reg;
    logic              buf_valid_reg, buf_valid_next;
    logic              s_fire, item_take;
    logic              out_free, res_valid;
    dtpm_pkg::result_t res, out_reg;
    logic              m_valid_reg, m_valid_next;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trie_words_reg   <= '0;
            string_bytes_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                dtpm_pkg::REG_TRIE_WORDS:   trie_words_reg   <= pwdata[dtpm_pkg::TW_W-1:0];
                dtpm_pkg::REG_STRING_BYTES: string_bytes_reg <= pwdata[dtpm_pkg::OFS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            dtpm_pkg::REG_TRIE_WORDS:   prdata = {15'b0, trie_words_reg};
            dtpm_pkg::REG_STRING_BYTES: prdata = {1'b0, string_bytes_reg};
            default:                    prdata = '0;
        endcase
    end

    // Input buffer: refill in the same cycle the walker drains it.
    assign s_ready        = !buf_valid_reg || item_take;
    assign s_fire         = s_valid && s_ready;
    assign buf_valid_next = s_fire ? 1'b1 : (item_take ? 1'b0 : buf_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
        end else begin
            buf_valid_reg <= buf_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            buf_reg.command    <= s_command;
            buf_reg.node_index <= s_node_index;
            buf_reg.node_word  <= s_node_word;
            buf_reg.text_byte  <= s_text_byte;
            buf_reg.first_byte <= s_first_byte;
            buf_reg.last_byte  <= s_last_byte;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    dtpm_walker #(
        .TRIE_DEPTH    (TRIE_DEPTH),
        .MAX_MATCH_LEN (MAX_MATCH_LEN)
    ) u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (buf_valid_reg),
        .item         (buf_reg),
        .item_take    (item_take),
        .out_free     (out_free),
        .trie_words   (trie_words_reg),
        .string_bytes (string_bytes_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    assign m_valid_next = res_valid ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_match_found  = out_reg.found;
    assign m_match_length = out_reg.length;
    assign m_value_offset = out_reg.offset;

endmodule

### sv/dtpm_checker.sv
`include "double_array_trie_prefix_match_macros.svh"

module dtpm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_command,
    input logic [15:0] s_node_index,
    input logic [31:0] s_node_word,
    input logic [7:0]  s_text_byte,
    input logic        s_first_byte,
    input logic        s_last_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_match_found,
    input logic [11:0] m_match_length,
    input logic [30:0] m_value_offset
);

    // Hold a stalled result.
    `DTPM_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_match_found) && $stable(m_match_length) && $stable(m_value_offset), "result changed while stalled")

    `DTPM_ASSERT_ALWAYS(a_reset_drop, !aresetn |=> !m_valid, "result valid after reset")

    // A miss carries no length and no offset.
    `DTPM_ASSERT(a_miss_zero, m_valid && !m_match_found |-> m_match_length == 12'd0 && m_value_offset == 31'd0, "miss with non-zero payload")

    // A hit consumed at least one byte.
    `DTPM_ASSERT(a_hit_len, m_valid && m_match_found |-> m_match_length != 12'd0, "hit with zero length")

endmodule

bind double_array_trie_prefix_match dtpm_checker u_dtpm_checker (.*);

### tb/dtpm_result_checker.sv
`timescale 1ns / 100ps

module dtpm_result_checker
    import dtpm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_command,
    input  logic [15:0] s_node_index,
    input  logic [31:0] s_node_word,
    input  logic [7:0]  s_text_byte,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_match_found,
    input  logic [11:0] m_match_length,
    input  logic [30:0] m_value_offset,
    output int          mismatches,
    output int          awaiting,
    output int          results_checked
);

    localparam int STORE_DEPTH = 65536;
    localparam int LENGTH_CAP  = 4095;

    logic [31:0] node_image [0:STORE_DEPTH-1];
    logic [16:0] cfg_words;
    logic [30:0] cfg_string;

    logic [31:0] cur_node;
    logic        alive;
    logic [11:0] depth;
    logic [11:0] best_len;
    logic [30:0] best_ofs;

    result_t expected_matches [$];

    // Words at or beyond the loaded count read as zero.
    function automatic logic [31:0] fetch_node(input logic [31:0] idx);
        if (idx >= {15'b0, cfg_words} || idx >= STORE_DEPTH) begin
            return '0;
        end
        return node_image[idx[15:0]];
    endfunction

    function automatic logic [31:0] hop_of(input logic [31:0] w);
        return w[9] ? {2'b0, w[31:10], 8'b0} : {10'b0, w[31:10]};
    endfunction

    task automatic track_item();
        logic [31:0] w;
        logic [31:0] v;
        result_t     r;
        if (s_command == CMD_LOAD) begin
            node_image[s_node_index] = s_node_word;
        end else begin
            if (s_first_byte) begin
                alive    = (cfg_words != 0);
                cur_node = hop_of(fetch_node(32'd0));
                depth    = '0;
                best_len = '0;
                best_ofs = '0;
            end
            if (alive) begin
                cur_node = cur_node ^ {24'b0, s_text_byte};
                w = fetch_node(cur_node);
                // label and check: bit 31 clear, low byte equal to the text byte
                if ({w[31], w[7:0]} != {1'b0, s_text_byte}) begin
                    alive = 1'b0;
                end else begin
                    cur_node = cur_node ^ hop_of(w);
                    if (depth < LENGTH_CAP) depth = depth + 12'd1;
                    if (w[8]) begin
                        v        = fetch_node(cur_node);
                        best_len = depth;
                        best_ofs = v[30:0];
                    end
                end
            end
            if (s_last_byte) begin
                r = '0;
                if (best_len != 0 && best_ofs < cfg_string) begin
                    r.found  = 1'b1;
                    r.length = best_len;
                    r.offset = best_ofs;
                end
                expected_matches.push_back(r);
            end
        end
    endtask

    task automatic check_result();
        result_t want;
        result_t got;
        got.found  = m_match_found;
        got.length = m_match_length;
        got.offset = m_value_offset;
        results_checked++;
        if (expected_matches.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d with no query waiting: found=%0b length=%0d offset=%0d",
                         results_checked, got.found, got.length, got.offset);
            end
        end else begin
            want = expected_matches.pop_front();
            if (got.found !== want.found || got.length !== want.length ||
                got.offset !== want.offset) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: expected found=%0b length=%0d offset=%0d, got found=%0b length=%0d offset=%0d",
                             results_checked, want.found, want.length, want.offset,
                             got.found, got.length, got.offset);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_words       = '0;
            cfg_string      = '0;
            cur_node        = '0;
            alive           = 1'b0;
            depth           = '0;
            best_len        = '0;
            best_ofs        = '0;
            mismatches      = 0;
            results_checked = 0;
            expected_matches.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_TRIE_WORDS) cfg_words = pwdata[16:0];
                else cfg_string = pwdata[30:0];
            end
            if (s_valid && s_ready) track_item();
            if (m_valid && m_ready) check_result();
        end
        awaiting = expected_matches.size();
    end

endmodule

### tb/tb_double_array_trie_prefix_match.sv
`timescale 1ns / 100ps

module tb_double_array_trie_prefix_match;
    import dtpm_pkg::*;

    localparam int         LOADED_WORDS  = 4096;
    localparam int         STORE_WORDS   = 65536;
    localparam int         NODES         = 15;
    localparam int         LOOP_NODE     = 14;
    localparam int         MAX_CHILDREN  = 4;
    localparam logic [7:0] LOOP_ENTRY    = 8'hA5;
    localparam logic [7:0] LOOP_STEP     = 8'h5A;
    localparam int         SETTLE_CYCLES = 16;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic        s_command    = 1'b0;
    logic [15:0] s_node_index = '0;
    logic [31:0] s_node_word  = '0;
    logic [7:0]  s_text_byte  = '0;
    logic        s_first_byte = 1'b0;
    logic        s_last_byte  = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic        m_match_found;
    logic [11:0] m_match_length;
    logic [30:0] m_value_offset;

    int mismatches;
    int awaiting;
    int results_checked;

    int send_idle = 0;
    int recv_idle = 0;
    int match_bytes = 0;
    int query_count = 0;
    int load_count = 0;

    // Stimulus-side image of the trie, loaded into the design and used to steer queries down real paths.
    logic [31:0] shadow     [0:STORE_WORDS-1];
    bit          structural [0:STORE_WORDS-1];
    logic [15:0] node_val   [NODES];
    int          child_cnt  [NODES];
    logic [7:0]  child_byte [NODES][MAX_CHILDREN];
    int          child_to   [NODES][MAX_CHILDREN];
    logic [7:0]  query_bytes [$];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    double_array_trie_prefix_match DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_node_index  (s_node_index),
        .s_node_word   (s_node_word),
        .s_text_byte   (s_text_byte),
        .s_first_byte  (s_first_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_found (m_match_found),
        .m_match_length(m_match_length),
        .m_value_offset(m_value_offset)
    );

    dtpm_result_checker result_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_node_index   (s_node_index),
        .s_node_word    (s_node_word),
        .s_text_byte    (s_text_byte),
        .s_first_byte   (s_first_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_match_found  (m_match_found),
        .m_match_length (m_match_length),
        .m_value_offset (m_value_offset),
        .mismatches     (mismatches),
        .awaiting       (awaiting),
        .results_checked(results_checked)
    );

    task automatic send_item(input logic cmd, input logic [15:0] idx, input logic [31:0] word,
                             input logic [7:0] tbyte, input logic ff, input logic lf);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_node_index <= idx;
        s_node_word  <= word;
        s_text_byte  <= tbyte;
        s_first_byte <= ff;
        s_last_byte  <= lf;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic load_word(input logic [15:0] idx, input logic [31:0] word);
        shadow[idx] = word;
        load_count++;
        send_item(CMD_LOAD, idx, word, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic ff, input logic lf);
        match_bytes++;
        send_item(CMD_MATCH, 16'($urandom), $urandom, b, ff, lf);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline drain.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaiting != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Hook child under parent on byte c; shift form is taken when the base allows it.
    task automatic add_edge(input int parent, input logic [7:0] c, input int child,
                            input logic leaf);
        logic [15:0] slot;
        logic [15:0] base;
        logic [31:0] word;
        slot = node_val[parent] ^ {8'b0, c};
        base = slot ^ node_val[child];
        if (base[7:0] == 8'h00) word = {14'b0, base[15:8], 1'b1, leaf, c};
        else word = {6'b0, base, 1'b0, leaf, c};
        shadow[slot]     = word;
        structural[slot] = 1'b1;
        if (leaf && !structural[node_val[child]]) begin
            shadow[node_val[child]] = {1'($urandom),
                ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(1500))};
            structural[node_val[child]] = 1'b1;
        end
        child_byte[parent][child_cnt[parent]] = c;
        child_to[parent][child_cnt[parent]]   = child;
        child_cnt[parent]++;
    endtask

    task automatic build_trie();
        int          p;
        logic [7:0]  c;
        logic [15:0] slot;
        for (int i = 0; i < STORE_WORDS; i++) begin
            shadow[i]     = $urandom;
            structural[i] = 1'b0;
        end
        for (int n = 0; n < NODES; n++) child_cnt[n] = 0;
        // root lives in block 1; word 0 points at it
        node_val[0]   = 16'h0100 | 16'($urandom_range(255));
        shadow[0]     = {6'b0, node_val[0], 1'b0, 9'($urandom)};
        structural[0] = 1'b1;
        // self-looping leaf in block 15, for long walks and length saturation
        node_val[LOOP_NODE] = 16'h0F00 | 16'($urandom_range(255));
        add_edge(0, LOOP_ENTRY, LOOP_NODE, 1'b1);
        add_edge(LOOP_NODE, LOOP_STEP, LOOP_NODE, 1'b1);
        shadow[node_val[LOOP_NODE]][30:0] = 31'd37;
        for (int n = 1; n < LOOP_NODE; n++) begin
            do begin
                p    = ($urandom_range(1) == 0) ? n - 1 : $urandom_range(n - 1);
                c    = 8'($urandom);
                slot = node_val[p] ^ {8'b0, c};
            end while (child_cnt[p] >= MAX_CHILDREN || structural[slot]);
            node_val[n][15:8] = 8'(n + 1);
            node_val[n][7:0]  = ($urandom_range(1) == 0) ? slot[7:0] : 8'($urandom);
            add_edge(p, c, n, 1'($urandom));
        end
    endtask

    task automatic mixed_load();
        logic [15:0] idx;
        idx = 16'($urandom);
        if (structural[idx]) load_word(idx, shadow[idx]);
        else load_word(idx, $urandom);
    endtask

    task automatic random_query();
        int  kind;
        int  node;
        int  len;
        int  k;
        bit  abandon;
        bit  ff;
        kind    = $urandom_range(99);
        abandon = ($urandom_range(19) == 0);
        query_bytes.delete();
        if (kind < 75) begin
            node = 0;
            len  = $urandom_range(1, 12);
            for (int i = 0; i < len && child_cnt[node] > 0; i++) begin
                k = $urandom_range(child_cnt[node] - 1);
                query_bytes.push_back(child_byte[node][k]);
                node = child_to[node][k];
            end
            // run off the end of the path
            if (kind >= 60) begin
                repeat ($urandom_range(1, 3)) query_bytes.push_back(8'($urandom));
            end
        end else begin
            repeat ($urandom_range(1, 6)) query_bytes.push_back(8'($urandom));
        end
        for (int i = 0; i < query_bytes.size(); i++) begin
            if ($urandom_range(99) < 8) mixed_load();
            if (kind < 90) ff = (i == 0);
            else ff = ($urandom_range(4) == 0);
            send_byte(query_bytes[i], ff, (i == query_bytes.size() - 1) && !abandon);
        end
        query_count++;
    endtask

    initial begin
        logic [15:0] step_slot;
        logic [31:0] saved_word;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle = 11;
        recv_idle = 76;
        build_trie();

        // a byte with no query started is dropped, its last flag still reports
        send_byte(8'hFF, 1'b0, 1'b1);
        // matching disabled while no words are counted
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(LOOP_ENTRY, 1'b1, 1'b1);
        load_word(16'hFFFF, 32'hFFFF_FFFF);
        load_word(16'hFFFF, 32'h0000_0000);
        for (int i = 0; i < LOADED_WORDS; i++) load_word(16'(i), shadow[i]);
        settle();
        write_reg(REG_TRIE_WORDS, LOADED_WORDS);
        write_reg(REG_STRING_BYTES, 32'h7FFF_FFFF);

        send_byte(LOOP_ENTRY, 1'b1, 1'b1);
        send_byte(LOOP_ENTRY, 1'b1, 1'b0);
        repeat (3) send_byte(LOOP_STEP, 1'b0, 1'b0);
        send_byte(LOOP_STEP, 1'b0, 1'b1);
        // break the loop word mid-walk, then restore it
        step_slot  = node_val[LOOP_NODE] ^ {8'b0, LOOP_STEP};
        saved_word = shadow[step_slot];
        send_byte(LOOP_ENTRY, 1'b1, 1'b0);
        load_word(step_slot, saved_word | 32'h8000_0000);
        send_byte(LOOP_STEP, 1'b0, 1'b1);
        load_word(step_slot, saved_word);
        send_byte(LOOP_ENTRY, 1'b1, 1'b0);
        send_byte(LOOP_STEP, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        // restart inside an open query
        send_byte(LOOP_ENTRY, 1'b1, 1'b0);
        send_byte(LOOP_ENTRY, 1'b1, 1'b1);

        while (match_bytes < 130) random_query();
        settle();
        write_reg(REG_TRIE_WORDS, $urandom_range(300, LOADED_WORDS - 1));
        write_reg(REG_STRING_BYTES, 500);
        while (match_bytes < 190) random_query();

        settle();
        send_idle = 76;
        recv_idle = 11;
        write_reg(REG_TRIE_WORDS, 0);
        repeat (3) random_query();
        settle();
        write_reg(REG_TRIE_WORDS, LOADED_WORDS);
        write_reg(REG_STRING_BYTES, 0);
        repeat (5) random_query();
        settle();
        write_reg(REG_STRING_BYTES, $urandom_range(1, 1500));
        while (match_bytes < 300) random_query();

        settle();
        send_idle = 0;
        recv_idle = 0;
        for (int i = LOADED_WORDS; i < STORE_WORDS; i++) load_word(16'(i), shadow[i]);
        settle();
        write_reg(REG_TRIE_WORDS, STORE_WORDS);
        write_reg(REG_STRING_BYTES, 32'h7FFF_FFFF);
        while (match_bytes < 400) random_query();
        // walk the loop long enough to saturate the length
        send_byte(LOOP_ENTRY, 1'b1, 1'b0);
        repeat (4200) send_byte(LOOP_STEP, 1'b0, 1'b0);
        send_byte(LOOP_STEP, 1'b0, 1'b1);
        settle();
        write_reg(REG_TRIE_WORDS, 256);
        repeat (4) random_query();
        settle();

        $display("Sent %0d match bytes in %0d queries and %0d node word loads;",
                 match_bytes, query_count, load_count);
        $display("checked %0d results across trie sizes 0 to 65536 and string sizes 0 to max.",
                 results_checked);
        if (mismatches == 0 && awaiting == 0) begin
            $display("[double_array_trie_prefix_match] OK");
        end else begin
            $display("[double_array_trie_prefix_match] ERROR");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timed out with %0d results outstanding", awaiting);
        $display("[double_array_trie_prefix_match] ERROR");
        $finish;
    end

endmodule
